/* rtl/aesbc_pkg.sv */
// Shared types, constants and byte functions for the AES block cipher.
`timescale 1ns / 1ps
package aesbc_pkg;

  localparam int unsigned KeyWordW  = 64;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned RkDepth   = 60;
  localparam int unsigned RkAddrW   = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned RoundW    = 4;

  localparam logic [CfgIdxW-1:0] CfgKeySize = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyW0   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyW3   = 3'd4;

  localparam logic [7:0] GfPoly = 8'h1b;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_LOAD,
    ST_EXP_GEN,
    ST_FIRST,
    ST_ROUND,
    ST_DONE
  } aesbc_state_e;

  typedef struct packed {
    logic         first;
    logic         last;
    logic         decrypt;
  } aesbc_rnd_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
 8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
 8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
 8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
 8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
 8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
 8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
 8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
 8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
 8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
 8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
 8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
 8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
 8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
 8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
 8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    fwd_sbox = t[a];
  endfunction

  function automatic logic [7:0] dec_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    dec_sbox = t[a];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    sbox_word = {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

endpackage

/* rtl/aesbc_round.sv */
// Shared AES round unit: the initial round-key addition, or one forward or inverse round on the 128-bit state.
`timescale 1ns / 1ps
module aesbc_round (
  input  logic [aesbc_pkg::BlockW-1:0] state_i,
  input  logic [aesbc_pkg::BlockW-1:0] rkey_i,
  input  aesbc_pkg::aesbc_rnd_ctl_t    ctl_i,
  output logic [aesbc_pkg::BlockW-1:0] state_o
);
  import aesbc_pkg::*;

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] k  [16];
  logic [7:0] ak [16];
  logic [7:0] m  [16];
  logic [7:0] a [4];
  logic [7:0] y2 [4];
  logic [7:0] y4 [4];
  logic [7:0] y8 [4];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[BlockW-1-8*i -: 8];
      k[i] = rkey_i[BlockW-1-8*i -: 8];
      t[i] = 8'h00;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl_i.decrypt) begin
          t[4*((c+r)%4)+r] = dec_sbox(s[4*c+r]);
        end else begin
          t[4*c+r] = fwd_sbox(s[4*((c+r)%4)+r]);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl_i.first) begin
        ak[i] = s[i] ^ k[i];
      end else begin
        ak[i] = t[i] ^ (ctl_i.decrypt ? k[i] : 8'h00);
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = ak[4*c+r];
        y2[r] = xtime(a[r]);
        y4[r] = xtime(y2[r]);
        y8[r] = xtime(y4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        if (ctl_i.decrypt) begin
          m[4*c+r] = (y8[r] ^ y4[r] ^ y2[r])
                   ^ (y8[(r+1)%4] ^ y2[(r+1)%4] ^ a[(r+1)%4])
                   ^ (y8[(r+2)%4] ^ y4[(r+2)%4] ^ a[(r+2)%4])
                   ^ (y8[(r+3)%4] ^ a[(r+3)%4]);
        end else begin
          m[4*c+r] = y2[r] ^ y2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl_i.first) begin
        state_o[BlockW-1-8*i -: 8] = ak[i];
      end else if (ctl_i.last) begin
        state_o[BlockW-1-8*i -: 8] = ak[i] ^ (ctl_i.decrypt ? 8'h00 : k[i]);
      end else if (ctl_i.decrypt) begin
        state_o[BlockW-1-8*i -: 8] = m[i];
      end else begin
        state_o[BlockW-1-8*i -: 8] = m[i] ^ k[i];
      end
    end
  end

endmodule

/* rtl/aesbc_keymem.sv */
// Round-key memory: 60 words written by key expansion, read as one 128-bit round key.
`timescale 1ns / 1ps
module aesbc_keymem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [aesbc_pkg::RkAddrW-1:0] waddr_i,
  input  logic [31:0]                  wdata_i,
  input  logic [aesbc_pkg::RoundW-1:0] rround_i,
  output logic [aesbc_pkg::BlockW-1:0] rdata_o
);
  import aesbc_pkg::*;

  logic [BlockW-1:0] mem_q [RkDepth/4];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i[RkAddrW-1:2]][BlockW-1-32*waddr_i[1:0] -: 32] <= wdata_i;
    end
    rdata_o <= mem_q[rround_i];
  end

endmodule

/* rtl/aes_block_cipher.sv */
// AES-128/192/256 ECB block cipher top level with key expansion sequencer.
//
// Usage: configure key_size (index 0) and key words (indices 1..4) through
// cfg_we_i/cfg_idx_i/cfg_data_i while idle. Each write to indices 0..4 restarts
// key expansion, which writes 44, 52 or 60 round-key words, one per cycle;
// busy_o is high meanwhile. A block request is taken when start_i is high and
// busy_o low. State ST_FIRST adds the first round key, then the shared round
// unit performs one round per cycle, Nr = 10, 12 or 14 rounds, and the result
// is shown with done_o. The result is on result_hi_o/result_lo_o for one
// cycle with done_o; the receiver cannot stall. busy_o stays high during that
// cycle, so a new request is taken the cycle after done_o; a block is not
// taken until the previous result is out.
// Reset clears key_size, key words and the cipher state; round keys are
// undefined until the first configuration write to indices 0..4.
`timescale 1ns / 1ps
module aes_block_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aesbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aesbc_pkg::KeyWordW-1:0] cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           mode_i,
  input  logic [63:0]                    block_hi_i,
  input  logic [63:0]                    block_lo_i,
  output logic                           done_o,
  output logic [63:0]                    result_hi_o,
  output logic [63:0]                    result_lo_o
);
  import aesbc_pkg::*;

  aesbc_state_e      state_q, state_d;
  logic [1:0]        ksize_q;
  logic [63:0]       kw_q [4];
  logic              exp_req_q, exp_req_d;
  logic [RkAddrW-1:0] widx_q, widx_d;
  logic [2:0]        modc_q, modc_d;
  logic [7:0]        rcon_q, rcon_d;
  logic [31:0]       w_hist_q [8];
  logic [31:0]       new_w;
  logic              we;
  logic [RoundW-1:0] rnd_q, rnd_d, rd_rnd;
  logic              dec_q, dec_d;
  logic [BlockW-1:0] st_q, st_d, rkey, rnd_out;
  aesbc_rnd_ctl_t    ctl;
  logic              done_q, done_d;
  logic [1:0]        esz;
  logic [3:0]        nk;
  logic [RoundW-1:0] nr;
  logic [RkAddrW:0]  total;
  logic [31:0]       t, tr;

  assign esz   = (ksize_q == 2'd3) ? 2'd2 : ksize_q;
  assign nk    = 4'd4 + {1'b0, esz, 1'b0};
  assign nr    = 4'd10 + {1'b0, esz, 1'b0};
  assign total = 7'd44 + {2'b0, esz, 3'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= 2'd0;
      for (int i = 0; i < 4; i++) kw_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgKeySize) ksize_q <= cfg_data_i[1:0];
      else if (cfg_idx_i >= CfgKeyW0 && cfg_idx_i <= CfgKeyW3)
        kw_q[2'(cfg_idx_i - CfgKeyW0)] <= cfg_data_i;
    end
  end

  assign exp_req_d = cfg_we_i && (cfg_idx_i <= CfgKeyW3);

  // key expansion: history of last nk words, newest at index 0
  always_comb begin
    t = w_hist_q[0];
    tr = {t[23:0], t[31:24]};
    if (state_q == ST_EXP_LOAD) begin
      new_w = widx_q[0] ? kw_q[widx_q[2:1]][31:0] : kw_q[widx_q[2:1]][63:32];
    end else if (modc_q == 3'd0) begin
      new_w = w_hist_q[3'(nk - 4'd1)] ^ sbox_word(tr) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && modc_q == 3'd4) begin
      new_w = w_hist_q[3'(nk - 4'd1)] ^ sbox_word(t);
    end else begin
      new_w = w_hist_q[3'(nk - 4'd1)] ^ t;
    end
  end

  assign we = (state_q == ST_EXP_LOAD) || (state_q == ST_EXP_GEN);

  always_ff @(posedge clk_i) begin
    if (we) begin
      w_hist_q[0] <= new_w;
      for (int i = 1; i < 8; i++) w_hist_q[i] <= w_hist_q[i-1];
    end
    dec_q <= dec_d;
    rnd_q <= rnd_d;
    modc_q <= modc_d;
    rcon_q <= rcon_d;
    widx_q <= widx_d;
  end

  assign rd_rnd = rnd_d;

  aesbc_keymem u_keymem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (widx_q),
    .wdata_i  (new_w),
    .rround_i (rd_rnd),
    .rdata_o  (rkey)
  );

  assign ctl.first   = (state_q == ST_FIRST);
  assign ctl.last    = dec_q ? (rnd_q == '0) : (rnd_q == nr);
  assign ctl.decrypt = dec_q;

  aesbc_round u_round (
    .state_i (st_q),
    .rkey_i  (rkey),
    .ctl_i   (ctl),
    .state_o (rnd_out)
  );

  always_comb begin
    state_d = state_q;
    widx_d  = widx_q;
    modc_d  = modc_q;
    rcon_d  = rcon_q;
    rnd_d   = rnd_q;
    dec_d   = dec_q;
    st_d    = st_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          dec_d   = mode_i;
          st_d    = {block_hi_i, block_lo_i};
          rnd_d   = mode_i ? nr : '0;
          state_d = ST_FIRST;
        end
      end
      ST_EXP_LOAD: begin
        widx_d = widx_q + 1'b1;
        if (widx_q == {2'b0, nk - 4'd1}) begin
          state_d = ST_EXP_GEN;
          modc_d  = 3'd0;
          rcon_d  = 8'h01;
        end
      end
      ST_EXP_GEN: begin
        widx_d = widx_q + 1'b1;
        modc_d = ({1'b0, modc_q} == nk - 4'd1) ? 3'd0 : modc_q + 3'd1;
        if (modc_q == 3'd0) rcon_d = xtime(rcon_q);
        if ({1'b0, widx_q} == total - 7'd1) state_d = ST_IDLE;
      end
      ST_FIRST, ST_ROUND: begin
        st_d    = rnd_out;
        rnd_d   = dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
        state_d = ST_ROUND;
        if (state_q == ST_ROUND && ctl.last) begin
          state_d = ST_DONE;
          done_d  = 1'b1;
          rnd_d   = rnd_q;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (exp_req_q) begin
      state_d = ST_EXP_LOAD;
      widx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      exp_req_q <= 1'b0;
      done_q    <= 1'b0;
      st_q      <= '0;
    end else begin
      state_q   <= state_d;
      exp_req_q <= exp_req_d;
      done_q    <= done_d;
      st_q      <= st_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE) || exp_req_q;
  assign done_o      = done_q;
  assign result_hi_o = st_q[127:64];
  assign result_lo_o = st_q[63:0];

endmodule

/* verif/aes_block_cipher_test.sv */
// Self-checking testbench for the AES-128/192/256 ECB block cipher.
`timescale 1ns / 1ps
module aes_block_cipher_test;
  import aesbc_pkg::*;

  localparam logic [CfgIdxW-1:0] IdxKeyW1 = CfgKeyW0 + 3'd1;
  localparam logic [CfgIdxW-1:0] IdxKeyW2 = CfgKeyW0 + 3'd2;
  localparam logic [CfgIdxW-1:0] IdxSpare5 = 3'd5;
  localparam logic [CfgIdxW-1:0] IdxSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxSpare7 = 3'd7;
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;
  localparam logic [1:0] Ks128 = 2'd0;
  localparam logic [1:0] Ks192 = 2'd1;
  localparam logic [1:0] Ks256 = 2'd2;
  localparam logic [1:0] KsSpare = 2'd3;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 20;

  typedef enum logic {ROW_CFG, ROW_BLK} row_kind_e;
  typedef struct {
    row_kind_e    kind;
    logic [2:0]   idx;
    logic [63:0]  data;
    logic         mode;
    logic [127:0] blk;
    bit           has_exp;
    logic [127:0] exp;
  } stim_row_t;

  logic clk_i, rst_ni, cfg_we_i, start_i, busy_o, mode_i, done_o;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [63:0] cfg_data_i, block_hi_i, block_lo_i, result_hi_o, result_lo_o;

  aes_block_cipher DUT (.*);

  logic [7:0]  sbox [256];
  logic [7:0]  isbox [256];
  logic [1:0]  key_size;
  logic [63:0] key_word [4];
  logic [31:0] round_key [60];
  logic [127:0] pending_q [$];
  stim_row_t   rows [$];
  int          errors = 0;
  int          burst_left = 0;
  int          idle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  // S-box built from the field inverse and the affine map
  function automatic void build_sboxes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox[x] = b;
      isbox[b] = x[7:0];
    end
  endfunction

  function automatic void expand_keys();
    int eff, nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    eff = (key_size > Ks256) ? 2 : int'(key_size);
    nk = 4 + 2 * eff;
    total = 4 * (11 + 2 * eff);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      round_key[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = round_key[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox[t[31:24]], sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]} ^ {rc, 24'h0};
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {sbox[t[31:24]], sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]};
      end
      round_key[i] = round_key[i - nk] ^ t;
    end
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [63:0] data);
    if (idx == CfgKeySize) key_size = data[1:0];
    else if (idx <= CfgKeyW3) key_word[idx - CfgKeyW0] = data;
    else return;
    expand_keys();
  endfunction

  function automatic logic [127:0] add_rk(logic [127:0] v, int rnd);
    return v ^ {round_key[(rnd * 4) % 60], round_key[(rnd * 4 + 1) % 60],
                round_key[(rnd * 4 + 2) % 60], round_key[(rnd * 4 + 3) % 60]};
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] v, bit dec);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (dec)
          t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = isbox[v[127 - 8 * (4 * c + r) -: 8]];
        else
          t[127 - 8 * (4 * c + r) -: 8] = sbox[v[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] v, bit dec);
    logic [7:0] a [4];
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = v[127 - 8 * (4 * c + r) -: 8];
      for (int r = 0; r < 4; r++) begin
        a0 = a[r]; a1 = a[(r + 1) % 4]; a2 = a[(r + 2) % 4]; a3 = a[(r + 3) % 4];
        v[127 - 8 * (4 * c + r) -: 8] = dec
          ? gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9)
          : xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      end
    end
    return v;
  endfunction

  function automatic logic [127:0] cipher_block(logic dec, logic [127:0] v);
    int nr;
    nr = 10 + 2 * ((key_size > Ks256) ? 2 : int'(key_size));
    if (dec == ModeEnc) begin
      v = add_rk(v, 0);
      for (int rnd = 1; rnd < nr; rnd++) v = add_rk(mix_cols(sub_shift(v, 0), 0), rnd);
      v = add_rk(sub_shift(v, 0), nr);
    end else begin
      v = add_rk(v, nr);
      for (int rnd = nr - 1; rnd > 0; rnd--) v = mix_cols(add_rk(sub_shift(v, 1), rnd), 1);
      v = add_rk(sub_shift(v, 1), 0);
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // results cannot be held off; check each strobe against the oldest request
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result_hi", result_hi_o, 64'h0);
      end else begin
        logic [127:0] want;
        want = pending_q.pop_front();
        if (result_hi_o !== want[127:64]) report_mismatch("result_hi", result_hi_o, want[127:64]);
        if (result_lo_o !== want[63:0]) report_mismatch("result_lo", result_lo_o, want[63:0]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("[aes_block_cipher] ERROR");
      $finish;
    end
  end

  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, data);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic send_block(logic md, logic [127:0] blk, bit has_exp, logic [127:0] exp);
    start_i <= 1'b1;
    mode_i <= md;
    block_hi_i <= blk[127:64];
    block_lo_i <= blk[63:0];
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(has_exp ? exp : cipher_block(md, blk));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  function automatic void cfg_row(logic [2:0] idx, logic [63:0] data);
    rows.push_back('{ROW_CFG, idx, data, ModeEnc, '0, 1'b0, '0});
  endfunction

  function automatic void blk_row(logic md, logic [127:0] blk, bit has_exp,
                                  logic [127:0] exp);
    rows.push_back('{ROW_CFG, '0, '0, md, blk, has_exp, exp});
    rows[$].kind = ROW_BLK;
  endfunction

  localparam logic [127:0] Pt    = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] Ct128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] Ct192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
  localparam logic [127:0] Ct256 = 128'h8ea2b7ca516745bfeafc49904b496089;

  initial begin
    logic [63:0] kw;
    logic md;
    logic [127:0] blk;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    start_i = 1'b0;
    mode_i = ModeEnc;
    block_hi_i = '0;
    block_lo_i = '0;
    key_size = Ks128;
    for (int i = 0; i < 4; i++) key_word[i] = '0;
    for (int i = 0; i < 60; i++) round_key[i] = '0;
    build_sboxes();

    cfg_row(CfgKeySize, Ks128);
    cfg_row(CfgKeyW0, 64'h0001020304050607);
    cfg_row(IdxKeyW1, 64'h08090a0b0c0d0e0f);
    blk_row(ModeEnc, Pt, 1, Ct128);
    blk_row(ModeDec, Ct128, 1, Pt);
    blk_row(ModeEnc, '0, 0, '0);
    blk_row(ModeEnc, '1, 0, '0);
    blk_row(ModeDec, '1, 0, '0);
    cfg_row(CfgKeySize, Ks192);
    cfg_row(IdxKeyW2, 64'h1011121314151617);
    blk_row(ModeEnc, Pt, 1, Ct192);
    blk_row(ModeDec, Ct192, 1, Pt);
    cfg_row(CfgKeySize, Ks256);
    cfg_row(CfgKeyW3, 64'h18191a1b1c1d1e1f);
    blk_row(ModeEnc, Pt, 1, Ct256);
    blk_row(ModeDec, Ct256, 1, Pt);
    // unused size code behaves as 256-bit
    cfg_row(CfgKeySize, KsSpare);
    blk_row(ModeEnc, Pt, 1, Ct256);
    // out-of-range indexes are dropped
    cfg_row(IdxSpare5, '1);
    cfg_row(IdxSpare6, '1);
    cfg_row(IdxSpare7, '1);
    blk_row(ModeDec, Ct256, 1, Pt);
    cfg_row(CfgKeyW0, '1);
    cfg_row(CfgKeySize, Ks128);
    blk_row(ModeEnc, '1, 0, '0);
    blk_row(ModeDec, '0, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_cfg(rows[i].idx, rows[i].data);
      end else begin
        send_block(rows[i].mode, rows[i].blk, rows[i].has_exp, rows[i].exp);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_cfg(CfgKeySize, {62'($urandom), ph < 3 ? 2'(ph) : 2'($urandom_range(0, 3))});
      for (int w = 0; w < 4; w++) begin
        case ($urandom_range(0, 7))
          0: kw = '0;
          1: kw = '1;
          default: kw = {$urandom, $urandom};
        endcase
        write_cfg(CfgKeyW0 + 3'(w), kw);
      end
      for (int n = 0; n < 60; n++) begin
        md = $urandom_range(0, 1);
        case ($urandom_range(0, 15))
          0: blk = '0;
          1: blk = '1;
          default: blk = {$urandom, $urandom, $urandom, $urandom};
        endcase
        send_block(md, blk, 0, '0);
      end
    end

    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("[aes_block_cipher] OK");
    else $display("[aes_block_cipher] ERROR");
    $finish;
  end

endmodule
